// ===== rtl/rrbd_pkg.sv =====
`default_nettype none
package rrbd_pkg;

    localparam int ADDR_W    = 21;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int FBW_W     = 11;
    localparam int POS_W     = 10;
    localparam int DIM_IN_W  = 11;
    localparam int STRIDE_W  = FBW_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int STAT_W    = 2;
    localparam int PH_W      = 2;

    localparam int DEF_MAX_DIM     = 1024;
    localparam int DEF_LENGTH_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 3'd6;

    localparam logic KIND_START = 1'b0;

    localparam logic [STAT_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd2;

    localparam logic [PH_W-1:0] PH_CTRL = 2'd0;
    localparam logic [PH_W-1:0] PH_FILL = 2'd1;
    localparam logic [PH_W-1:0] PH_LIT  = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_value;
        logic [CNT_W-1:0]  write_count;
        logic [STAT_W-1:0] status;
        logic              last_of_item;
    } out_item_t;

    typedef struct packed {
        logic [FBW_W-1:0]    fb_width;
        logic [POS_W-1:0]    rect_left;
        logic [POS_W-1:0]    rect_top;
        logic [DIM_IN_W-1:0] rect_width;
        logic [DIM_IN_W-1:0] rect_height;
        logic                compressed;
    } cfg_t;

    typedef struct packed {
        logic ld_start;
        logic fin_start;
        logic dec_byte;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic seg_last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rle_rectangle_blit_decoder_top.sv =====
`default_nettype none
// Byte-RLE rectangle blit decoder. A start beat (kind 0) latches the register
// set and opens a frame; each payload beat (kind 1) yields one or more write
// segments for an RGB565 rectangle, the final one flagged last_of_item and
// carrying the frame status. Registers are written through cfg_we/cfg_index/
// cfg_data and take effect at the next start beat; write them only while idle.
// Sequence: a start beat passes through the setup multiply, then the address/size
// finish, then its empty result. A payload beat is decoded, then its results
// are emitted; a fill run crossing row ends yields one segment per row
// touched, in turn, from the single segment generator. A full output
// register that is not taken stalls segment generation. One beat is in work at
// a time.
module rle_rectangle_blit_decoder_top #(
    parameter int  MAX_DIM     = rrbd_pkg::DEF_MAX_DIM,
    parameter int  LENGTH_BITS = rrbd_pkg::DEF_LENGTH_BITS,
    localparam int CFG_W       = (LENGTH_BITS > rrbd_pkg::FBW_W) ? LENGTH_BITS
                                                                 : rrbd_pkg::FBW_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  rrbd_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output rrbd_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [rrbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data
);
    import rrbd_pkg::*;

    cfg_t                   cfg;
    logic [LENGTH_BITS-1:0] payload_length;
    dp_cmd_t                cmd;
    dp_stat_t               stat;

    rrbd_cfg #(
        .LENGTH_BITS (LENGTH_BITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cfg            (cfg),
        .payload_length (payload_length)
    );

    rrbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrbd_dp #(
        .MAX_DIM     (MAX_DIM),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .payload_length (payload_length),
        .in_byte        (in_data.data_byte),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_data       (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/rrbd_cfg.sv =====
`default_nettype none
module rrbd_cfg #(
    parameter int LENGTH_BITS = 24,
    parameter int CFG_W       = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data,
    output rrbd_pkg::cfg_t                      cfg,
    output logic [LENGTH_BITS-1:0]              payload_length
);
    import rrbd_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        len_next = len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FB_WIDTH:       cfg_next.fb_width    = cfg_data[FBW_W-1:0];
                REG_RECT_LEFT:      cfg_next.rect_left   = cfg_data[POS_W-1:0];
                REG_RECT_TOP:       cfg_next.rect_top    = cfg_data[POS_W-1:0];
                REG_RECT_WIDTH:     cfg_next.rect_width  = cfg_data[DIM_IN_W-1:0];
                REG_RECT_HEIGHT:    cfg_next.rect_height = cfg_data[DIM_IN_W-1:0];
                REG_COMPRESSED:     cfg_next.compressed  = cfg_data[0];
                REG_PAYLOAD_LENGTH: len_next             = cfg_data[LENGTH_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_width    <= FBW_W'(1);
            cfg_reg.rect_left   <= '0;
            cfg_reg.rect_top    <= '0;
            cfg_reg.rect_width  <= DIM_IN_W'(1);
            cfg_reg.rect_height <= DIM_IN_W'(1);
            cfg_reg.compressed  <= 1'b0;
            len_reg             <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            len_reg <= len_next;
        end
    end

    assign cfg            = cfg_reg;
    assign payload_length = len_reg;

endmodule
`default_nettype wire

// ===== rtl/rrbd_ctrl.sv =====
`default_nettype none
module rrbd_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_kind,
    output logic              in_ready,
    input  rrbd_pkg::dp_stat_t stat,
    output rrbd_pkg::dp_cmd_t  cmd
);
    import rrbd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_PUT   = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == KIND_START)
                    begin
                        cmd.ld_start = 1'b1;
                        state_next   = S_START;
                    end
                    else
                    begin
                        cmd.dec_byte = 1'b1;
                        state_next   = S_PUT;
                    end
                end
            end
            S_START:
            begin
                cmd.fin_start = 1'b1;
                state_next    = S_PUT;
            end
            S_PUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.seg_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rrbd_dp.sv =====
`default_nettype none
module rrbd_dp #(
    parameter int MAX_DIM     = 1024,
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  rrbd_pkg::cfg_t                   cfg,
    input  wire logic [LENGTH_BITS-1:0]      payload_length,
    input  wire logic [rrbd_pkg::BYTE_W-1:0] in_byte,
    input  rrbd_pkg::dp_cmd_t                cmd,
    output rrbd_pkg::dp_stat_t               stat,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output rrbd_pkg::out_item_t              out_data
);
    import rrbd_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = DIM_W + 1;
    localparam int AREA_W = 2 * DIM_W;
    localparam int TOT_W  = AREA_W + 1;
    localparam int CMP_W  = (LENGTH_BITS > TOT_W) ? LENGTH_BITS : TOT_W;
    localparam int SEG_W  = (ROW_W > CNT_W) ? ROW_W : CNT_W;
    localparam int PROD_W = POS_W + STRIDE_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_IN_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // frame setup
    logic [LENGTH_BITS-1:0] frame_len_reg, frame_len_next;
    logic                   frame_comp_reg, frame_comp_next;
    logic [STRIDE_W-1:0]    stride_reg;
    logic [ROW_W-1:0]       row_bytes_reg;
    logic [AREA_W-1:0]      area_reg;
    logic [ADDR_W-1:0]      top_prod_reg;
    logic [POS_W-1:0]       left_reg;
    logic [ADDR_W-1:0]      row_jump_reg;

    // walk state
    logic [ADDR_W-1:0]      row_addr_reg, row_addr_next;
    logic [ROW_W-1:0]       row_rem_reg, row_rem_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [LENGTH_BITS-1:0] consumed_reg, consumed_next;
    logic                   rejected_reg, rejected_next;
    logic [PH_W-1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]       run_left_reg, run_left_next;
    logic [CNT_W-1:0]       put_n_reg, put_n_next;
    logic [BYTE_W-1:0]      put_v_reg;
    logic                   start_flag_reg, start_flag_next;
    logic                   end_frame_reg, end_frame_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg;

    logic [DIM_W-1:0]       w_clamp, h_clamp;
    logic [STRIDE_W-1:0]    stride_in;
    logic [PROD_W-1:0]      top_prod;
    logic [TOT_W-1:0]       total_start;
    logic                   rejected_start;

    logic                   has_room;
    logic [LENGTH_BITS-1:0] consumed_inc;
    logic [CNT_W-1:0]       dec_n;
    logic [PH_W-1:0]        dec_phase;
    logic [CNT_W-1:0]       dec_run;

    logic [SEG_W-1:0]       n_ext, rr_ext;
    logic [CNT_W-1:0]       seg_cnt;
    logic                   active;
    logic [TOT_W-1:0]       total_after;
    logic [CNT_W-1:0]       put_n_after;
    logic [ROW_W-1:0]       rr_after;
    logic [ADDR_W-1:0]      addr_after;
    logic                   seg_last;
    logic [STAT_W-1:0]      end_status;
    out_item_t              seg_item;

    assign w_clamp   = clamp_dim(cfg.rect_width);
    assign h_clamp   = clamp_dim(cfg.rect_height);
    assign stride_in = {cfg.fb_width, 1'b0};
    assign top_prod  = PROD_W'(cfg.rect_top) * PROD_W'(stride_in);

    assign total_start    = {area_reg, 1'b0};
    assign rejected_start = !frame_comp_reg
                            && (CMP_W'(frame_len_reg) < CMP_W'(total_start));

    // payload byte decode
    assign has_room     = consumed_reg < frame_len_reg;
    assign consumed_inc = consumed_reg + LENGTH_BITS'(1);

    always_comb
    begin
        dec_n     = '0;
        dec_phase = phase_reg;
        dec_run   = run_left_reg;
        if (has_room)
        begin
            if (!frame_comp_reg)
            begin
                dec_n = rejected_reg ? '0 : CNT_W'(1);
            end
            else
            begin
                case (phase_reg)
                    PH_CTRL:
                    begin
                        dec_phase = in_byte[BYTE_W-1] ? PH_LIT : PH_FILL;
                        dec_run   = in_byte[CNT_W-1:0];
                    end
                    PH_FILL:
                    begin
                        dec_n     = run_left_reg;
                        dec_run   = '0;
                        dec_phase = PH_CTRL;
                    end
                    PH_LIT:
                    begin
                        dec_n = CNT_W'(1);
                        if (run_left_reg == '0)
                            dec_phase = PH_CTRL;
                        else
                            dec_run = run_left_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        dec_phase = PH_CTRL;
                    end
                endcase
            end
        end
    end

    // one segment per emit, split at row ends
    assign n_ext       = SEG_W'(put_n_reg);
    assign rr_ext      = SEG_W'(row_rem_reg);
    assign seg_cnt     = CNT_W'((n_ext < rr_ext) ? n_ext : rr_ext);
    assign active      = (put_n_reg != '0) && (total_reg != '0);
    assign total_after = active ? (total_reg - TOT_W'(seg_cnt)) : total_reg;
    assign put_n_after = put_n_reg - seg_cnt;
    assign rr_after    = row_rem_reg - ROW_W'(seg_cnt);
    assign addr_after  = row_addr_reg + ADDR_W'(seg_cnt);
    assign seg_last    = !active || (put_n_after == '0) || (total_after == '0);

    always_comb
    begin
        if (start_flag_reg)
            end_status = (frame_len_reg == '0) ? ST_FAIL : ST_BUSY;
        else if (end_frame_reg)
            end_status = (total_after == '0) ? ST_OK : ST_FAIL;
        else
            end_status = ST_BUSY;
    end

    always_comb
    begin
        seg_item.write_address = active ? row_addr_reg : '0;
        seg_item.write_value   = active ? put_v_reg : '0;
        seg_item.write_count   = active ? seg_cnt : '0;
        seg_item.status        = seg_last ? end_status : ST_BUSY;
        seg_item.last_of_item  = seg_last;
    end

    always_comb
    begin
        frame_len_next  = frame_len_reg;
        frame_comp_next = frame_comp_reg;
        row_addr_next   = row_addr_reg;
        row_rem_next    = row_rem_reg;
        total_next      = total_reg;
        consumed_next   = consumed_reg;
        rejected_next   = rejected_reg;
        phase_next      = phase_reg;
        run_left_next   = run_left_reg;
        put_n_next      = put_n_reg;
        start_flag_next = start_flag_reg;
        end_frame_next  = end_frame_reg;

        if (cmd.ld_start)
        begin
            frame_len_next  = payload_length;
            frame_comp_next = cfg.compressed;
        end

        if (cmd.fin_start)
        begin
            row_addr_next   = top_prod_reg + ADDR_W'({left_reg, 1'b0});
            row_rem_next    = row_bytes_reg;
            total_next      = total_start;
            consumed_next   = '0;
            rejected_next   = rejected_start;
            phase_next      = PH_CTRL;
            run_left_next   = '0;
            put_n_next      = '0;
            start_flag_next = 1'b1;
            end_frame_next  = 1'b0;
        end

        if (cmd.dec_byte)
        begin
            start_flag_next = 1'b0;
            put_n_next      = dec_n;
            phase_next      = dec_phase;
            run_left_next   = dec_run;
            end_frame_next  = has_room && (consumed_inc == frame_len_reg);
            if (has_room)
                consumed_next = consumed_inc;
        end

        if (cmd.emit && active)
        begin
            put_n_next = put_n_after;
            total_next = total_after;
            if ((rr_after == '0) && (total_after != '0))
            begin
                row_addr_next = addr_after + row_jump_reg;
                row_rem_next  = row_bytes_reg;
            end
            else
            begin
                row_addr_next = addr_after;
                row_rem_next  = rr_after;
            end
        end
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg  <= '0;
            frame_comp_reg <= 1'b0;
            row_addr_reg   <= '0;
            row_rem_reg    <= '0;
            total_reg      <= '0;
            consumed_reg   <= '0;
            rejected_reg   <= 1'b0;
            phase_reg      <= PH_CTRL;
            run_left_reg   <= '0;
            put_n_reg      <= '0;
            start_flag_reg <= 1'b0;
            end_frame_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_len_reg  <= frame_len_next;
            frame_comp_reg <= frame_comp_next;
            row_addr_reg   <= row_addr_next;
            row_rem_reg    <= row_rem_next;
            total_reg      <= total_next;
            consumed_reg   <= consumed_next;
            rejected_reg   <= rejected_next;
            phase_reg      <= phase_next;
            run_left_reg   <= run_left_next;
            put_n_reg      <= put_n_next;
            start_flag_reg <= start_flag_next;
            end_frame_reg  <= end_frame_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_start)
        begin
            stride_reg    <= stride_in;
            row_bytes_reg <= {w_clamp, 1'b0};
            area_reg      <= AREA_W'(w_clamp) * AREA_W'(h_clamp);
            top_prod_reg  <= ADDR_W'(top_prod);
            left_reg      <= cfg.rect_left;
        end
        if (cmd.fin_start)
        begin
            row_jump_reg <= ADDR_W'(stride_reg) - ADDR_W'(row_bytes_reg);
        end
        if (cmd.dec_byte)
        begin
            put_v_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            out_data_reg <= seg_item;
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.seg_last  = seg_last;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && seg_last) |=> (put_n_reg == '0 || total_reg == '0))
        else $error("segment run not drained after last beat");

    a_row_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (row_rem_reg != '0))
        else $error("row exhausted while rectangle unfinished");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0 && !cmd.fin_start && !start_flag_reg)
            |-> (row_rem_reg <= row_bytes_reg))
        else $error("row remainder exceeds row size");

    a_ctrl_run: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CTRL) |-> (run_left_reg == '0))
        else $error("run count left over in control phase");

endmodule
`default_nettype wire
